### hw/rtl/rect_polar_converter_defines.svh
// Assertion macros used by the checker file of the rectangular/polar converter.
`ifndef RECT_POLAR_CONVERTER_DEFINES_SVH
`define RECT_POLAR_CONVERTER_DEFINES_SVH

// Checked on every rising clock edge, ignored while reset is high.
`define RPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/rpc_pkg.sv
// Shared constants, types and the arctangent table of the rectangular/polar converter.
package rpc_pkg;

  // Configuration of the rotation chain and the coordinate range.
  localparam int ROTATION_STEPS = 16;
  localparam int COORD_WIDTH    = 16;
  localparam int MAX_TABLE      = 24;
  localparam int STEPS          = (ROTATION_STEPS < MAX_TABLE) ? ROTATION_STEPS : MAX_TABLE;
  localparam int COORD_BITS     = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam int STEP_W         = $clog2(MAX_TABLE);

  // Datapath widths: coordinates in units of 2^-14 or 2^-16, angles in 2^-16 degree.
  localparam int DATA_W = 35;
  localparam int ANG_W  = 27;
  localparam int ATAN_W = 22;
  localparam int PROD_W = DATA_W + 17;

  // Gain correction, 39797 / 2^16.
  localparam logic signed [16:0] GAIN_S = 17'sd39797;

  // Angle constants in units of 2^-16 degree.
  localparam logic signed [ANG_W-1:0] DEG_90  = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(180 * 65536);
  localparam logic signed [ANG_W-1:0] DEG_360 = ANG_W'(360 * 65536);

  // Output limits.
  localparam int ANG_LIMIT = 23040;
  localparam int COORD_LIM = 2 ** (COORD_BITS - 1);
  localparam logic signed [15:0] COORD_MAX = 16'(COORD_LIM - 1);
  localparam logic signed [15:0] COORD_MIN = 16'(-COORD_LIM);
  localparam logic signed [16:0] MAG_MAX   = 17'sh0FFFF;
  localparam logic signed [16:0] MAG_MIN   = 17'sh10000;

  // atan(2^-i) in units of 2^-16 degree.
  localparam logic [ATAN_W-1:0] ATAN_TAB [0:MAX_TABLE-1] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef enum logic {
    OP_RECT  = 1'b0,
    OP_POLAR = 1'b1
  } rpc_op_t;

  // One item as it travels down the rotation chain.
  typedef struct packed {
    rpc_op_t                   op;
    logic                      zero;
    logic signed [DATA_W-1:0]  x;
    logic signed [DATA_W-1:0]  y;
    logic signed [ANG_W-1:0]   z;
    logic signed [15:0]        a_echo;
    logic signed [15:0]        b_echo;
  } rpc_beat_t;

endpackage

### hw/rtl/rpc_prep.sv
// Entry stage: folds the input vector into the right half plane and sets up the rotation.
module rpc_prep import rpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  rpc_op_t            op,
  input  logic signed [15:0] first_value,
  input  logic signed [15:0] second_value,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rpc_beat_t          dn_beat
);

  logic                     valid;
  rpc_beat_t                beat;
  rpc_beat_t                beat_next;
  logic signed [DATA_W-1:0] xr;
  logic signed [DATA_W-1:0] yr;
  logic signed [ANG_W-1:0]  zr;
  logic signed [ANG_W-1:0]  zp;
  logic                     neg_m;
  logic signed [16:0]       m;
  logic signed [33:0]       prod;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_beat  = beat;

  // Start values for both modes.
  always_comb begin
    // Rectangular: scale by 2^14, mirror a left half plane vector.
    xr = DATA_W'(first_value) <<< 14;
    yr = DATA_W'(second_value) <<< 14;
    zr = '0;
    if (first_value < 0) begin
      xr = -xr;
      yr = -yr;
      zr = (second_value >= 0) ? DEG_180 : -DEG_180;
    end

    // Polar: wrap the angle into +-180 and fold it into +-90 degrees.
    zp = ANG_W'(second_value) <<< 9;
    if (zp > DEG_180) begin
      zp = zp - DEG_360;
    end
    if (zp < -DEG_180) begin
      zp = zp + DEG_360;
    end
    neg_m = 1'b0;
    if (zp > DEG_90) begin
      zp    = zp - DEG_180;
      neg_m = 1'b1;
    end else if (zp < -DEG_90) begin
      zp    = zp + DEG_180;
      neg_m = 1'b1;
    end
    m    = neg_m ? -17'(first_value) : 17'(first_value);
    prod = 34'(m) * 34'(GAIN_S);

    beat_next.op     = op;
    beat_next.a_echo = first_value;
    beat_next.b_echo = second_value;
    if (op == OP_POLAR) begin
      beat_next.zero = 1'b0;
      beat_next.x    = DATA_W'(prod);
      beat_next.y    = '0;
      beat_next.z    = zp;
    end else begin
      beat_next.zero = (first_value == 16'sd0) && (second_value == 16'sd0);
      beat_next.x    = xr;
      beat_next.y    = yr;
      beat_next.z    = zr;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      beat <= beat_next;
    end
  end

endmodule

### hw/rtl/rpc_cell.sv
// One rotation step of the chain: shift-add on x and y, table step on the angle.
module rpc_cell import rpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [STEP_W-1:0] step,
  input  logic              up_valid,
  output logic              up_ready,
  input  rpc_beat_t         up_beat,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rpc_beat_t         dn_beat
);

  logic                     valid;
  rpc_beat_t                beat;
  rpc_beat_t                beat_next;
  logic signed [DATA_W-1:0] dx;
  logic signed [DATA_W-1:0] dy;
  logic signed [ANG_W-1:0]  atan_s;
  logic                     pos;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_beat  = beat;

  // Polar mode drives the angle to zero, rectangular mode drives y to zero.
  always_comb begin
    dx     = up_beat.y >>> step;
    dy     = up_beat.x >>> step;
    atan_s = signed'(ANG_W'(ATAN_TAB[step]));
    pos    = (up_beat.op == OP_POLAR) ? !up_beat.z[ANG_W-1] : up_beat.y[DATA_W-1];

    beat_next = up_beat;
    if (pos) begin
      beat_next.x = up_beat.x - dx;
      beat_next.y = up_beat.y + dy;
      beat_next.z = up_beat.z - atan_s;
    end else begin
      beat_next.x = up_beat.x + dx;
      beat_next.y = up_beat.y - dy;
      beat_next.z = up_beat.z + atan_s;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      beat <= beat_next;
    end
  end

endmodule

### hw/rtl/rpc_finish.sv
// Exit stages: gain correction product, then rounding, clipping and the output register.
module rpc_finish import rpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  rpc_beat_t          up_beat,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] x_out,
  output logic signed [15:0] y_out,
  output logic signed [16:0] mag_out,
  output logic signed [15:0] ang_out,
  output logic               saturated
);

  logic                      p_valid;
  rpc_beat_t                 p_beat;
  logic signed [PROD_W-1:0]  prod;
  logic                      p_ready;
  logic                      r_ready;

  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [PROD_W-31:0] mag_w;
  logic signed [ANG_W-1:0]   z_rnd;
  logic signed [ANG_W-10:0]  ang_w;
  logic signed [DATA_W-1:0]  x_rnd;
  logic signed [DATA_W-1:0]  y_rnd;
  logic signed [DATA_W-17:0] x_w;
  logic signed [DATA_W-17:0] y_w;

  logic signed [15:0]        x_next;
  logic signed [15:0]        y_next;
  logic signed [16:0]        mag_next;
  logic signed [15:0]        ang_next;
  logic                      sat_next;

  assign r_ready  = !result_valid || !result_stall;
  assign p_ready  = !p_valid || r_ready;
  assign up_ready = p_ready;

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && p_ready) begin
      p_beat <= up_beat;
      prod   <= PROD_W'(up_beat.x) * PROD_W'(GAIN_S);
    end
  end

  // Round half up with floor shifts, then clip.
  always_comb begin
    prod_rnd = prod + (PROD_W'(1) <<< 29);
    mag_w    = prod_rnd[PROD_W-1:30];
    z_rnd    = p_beat.z + ANG_W'(256);
    ang_w    = z_rnd[ANG_W-1:9];
    x_rnd    = p_beat.x + DATA_W'(32768);
    y_rnd    = p_beat.y + DATA_W'(32768);
    x_w      = x_rnd[DATA_W-1:16];
    y_w      = y_rnd[DATA_W-1:16];
    sat_next = 1'b0;

    if (p_beat.op == OP_POLAR) begin
      mag_next = 17'(p_beat.a_echo);
      ang_next = p_beat.b_echo;
      if (x_w > COORD_LIM - 1) begin
        x_next   = COORD_MAX;
        sat_next = 1'b1;
      end else if (x_w < -COORD_LIM) begin
        x_next   = COORD_MIN;
        sat_next = 1'b1;
      end else begin
        x_next = 16'(x_w);
      end
      if (y_w > COORD_LIM - 1) begin
        y_next   = COORD_MAX;
        sat_next = 1'b1;
      end else if (y_w < -COORD_LIM) begin
        y_next   = COORD_MIN;
        sat_next = 1'b1;
      end else begin
        y_next = 16'(y_w);
      end
    end else begin
      x_next = p_beat.a_echo;
      y_next = p_beat.b_echo;
      if (p_beat.zero) begin
        mag_next = '0;
        ang_next = '0;
      end else begin
        if (mag_w > 65535) begin
          mag_next = MAG_MAX;
          sat_next = 1'b1;
        end else if (mag_w < -65536) begin
          mag_next = MAG_MIN;
          sat_next = 1'b1;
        end else begin
          mag_next = 17'(mag_w);
        end
        if (ang_w > ANG_LIMIT) begin
          ang_next = 16'(ANG_LIMIT);
        end else if (ang_w < -ANG_LIMIT) begin
          ang_next = 16'(-ANG_LIMIT);
        end else begin
          ang_next = 16'(ang_w);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (r_ready) begin
      result_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && r_ready) begin
      x_out     <= x_next;
      y_out     <= y_next;
      mag_out   <= mag_next;
      ang_out   <= ang_next;
      saturated <= sat_next;
    end
  end

endmodule

### hw/rtl/rect_polar_converter.sv
// Top level of the rectangular/polar converter: entry stage, rotation chain, exit stages.
//
//   channel  | handshake                  | beat fields
//   ---------+----------------------------+-------------------------------------------
//   item     | item_valid / item_stall    | op, first_value, second_value
//   result   | result_valid / result_stall| x_out, y_out, mag_out, ang_out, saturated
//
// One beat is taken per clock while item_stall is low, and each result passes through
// one entry stage with the start multiply, one register per rotation cell, one gain
// product stage and the output register.
// Every stage holds its beat while the one after it is full, so bubbles close up.
// Reset is synchronous and clears only the valid bit of each stage.
module rect_polar_converter import rpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               op,
  input  logic signed [15:0] first_value,
  input  logic signed [15:0] second_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] x_out,
  output logic signed [15:0] y_out,
  output logic signed [16:0] mag_out,
  output logic signed [15:0] ang_out,
  output logic               saturated
);

  logic      chain_valid [0:STEPS];
  logic      chain_ready [0:STEPS];
  rpc_beat_t chain_beat  [0:STEPS];
  logic      prep_ready;

  assign item_stall = !prep_ready;

  // Entry stage.
  rpc_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (item_valid),
    .up_ready     (prep_ready),
    .op           (rpc_op_t'(op)),
    .first_value  (first_value),
    .second_value (second_value),
    .dn_valid     (chain_valid[0]),
    .dn_ready     (chain_ready[0]),
    .dn_beat      (chain_beat[0])
  );

  // Rotation chain, one cell per step.
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    rpc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (STEP_W'(i)),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_beat  (chain_beat[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_beat  (chain_beat[i+1])
    );
  end

  // Exit stages.
  rpc_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (chain_valid[STEPS]),
    .up_ready     (chain_ready[STEPS]),
    .up_beat      (chain_beat[STEPS]),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .x_out        (x_out),
    .y_out        (y_out),
    .mag_out      (mag_out),
    .ang_out      (ang_out),
    .saturated    (saturated)
  );

endmodule

### hw/rtl/rpc_checker.sv
// Port-level assertions for the rectangular/polar converter, bound to its top level.
`include "rect_polar_converter_defines.svh"

module rpc_checker import rpc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [15:0] x_out,
  input logic signed [15:0] y_out,
  input logic signed [16:0] mag_out,
  input logic               saturated
);

  logic at_limit;

  // True when some output value sits at one of its clip limits.
  assign at_limit = (x_out == COORD_MAX) || (x_out == COORD_MIN) || (y_out == COORD_MAX) ||
                    (y_out == COORD_MIN) || (mag_out == MAG_MAX) || (mag_out == MAG_MIN);

  // A result beat that is held back stays offered.
  `RPC_ASSERT(a_result_held, result_valid && result_stall |=> result_valid, "result beat dropped while stalled")

  // A raised flag always comes with a value sitting at a clip limit.
  `RPC_ASSERT(a_sat_at_limit, result_valid && saturated |-> at_limit, "saturated without a clipped value")

  // Reset empties every stage, so nothing is offered and input is open.
  `RPC_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid && !item_stall, "pipeline not empty after reset")

endmodule

bind rect_polar_converter rpc_checker u_rpc_checker (.*);
